[sv/tsq_pkg.sv]
// Shared constants, types and register codes for the touch sample qualifier.
package tsq_pkg;

  // Default widths of coordinates and tick counters
  localparam int unsigned TSQ_COORD_BITS = 12;
  localparam int unsigned TSQ_TIME_BITS  = 16;

  // Fixed field widths
  localparam int unsigned ELAPSED_BITS  = 16;
  localparam int unsigned REPEAT_BITS   = 16;
  localparam int unsigned SCREEN_BITS   = 12;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // Register reset values
  localparam logic [REPEAT_BITS-1:0] RST_START_DELAY = 16'd20;
  localparam logic [REPEAT_BITS-1:0] RST_INTERVAL    = 16'd6;
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_W    = 12'h100;
  localparam logic [SCREEN_BITS-1:0] RST_SCREEN_H    = 12'hC0;

  // Last touched position after reset (screen centre)
  localparam int unsigned HELD_RST_X = 128;
  localparam int unsigned HELD_RST_Y = 96;

  // Item codes
  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_ADD_TIME = 1'b1
  } tsq_op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_START_DELAY = 2'd0,
    CFG_INTERVAL    = 2'd1,
    CFG_SCREEN_W    = 2'd2,
    CFG_SCREEN_H    = 2'd3
  } tsq_cfg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic [REPEAT_BITS-1:0] start_delay;
    logic [REPEAT_BITS-1:0] interval;
    logic [SCREEN_BITS-1:0] screen_w;
    logic [SCREEN_BITS-1:0] screen_h;
  } tsq_cfg_t;

endpackage

[sv/tsq_if.sv]
// Valid/ready channel interfaces for touch samples and qualified results.
interface tsq_in_if import tsq_pkg::*; #(
  parameter int unsigned COORD_BITS = TSQ_COORD_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic                    pen_down;
  logic                    lid_closed;
  logic                    invalid_x;
  logic                    invalid_y;
  logic [COORD_BITS-1:0]   sample_x;
  logic [COORD_BITS-1:0]   sample_y;
  logic [ELAPSED_BITS-1:0] elapsed;

  modport source (
    output valid, opcode, pen_down, lid_closed, invalid_x, invalid_y,
           sample_x, sample_y, elapsed,
    input  ready
  );
  modport sink (
    input  valid, opcode, pen_down, lid_closed, invalid_x, invalid_y,
           sample_x, sample_y, elapsed,
    output ready
  );
endinterface

interface tsq_out_if import tsq_pkg::*; #(
  parameter int unsigned COORD_BITS = TSQ_COORD_BITS,
  parameter int unsigned TIME_BITS  = TSQ_TIME_BITS
) ();
  logic                         valid;
  logic                         ready;
  logic                         touching;
  logic signed [COORD_BITS:0]   pos_x;
  logic signed [COORD_BITS:0]   pos_y;
  logic                         touched_now;
  logic                         released_now;
  logic                         repeat_pulse;
  logic [TIME_BITS-1:0]         time_since_touch;
  logic [TIME_BITS-1:0]         time_between_touches;
  logic signed [COORD_BITS:0]   start_x;
  logic signed [COORD_BITS:0]   start_y;
  logic signed [COORD_BITS:0]   last_x;
  logic signed [COORD_BITS:0]   last_y;

  modport source (
    output valid, touching, pos_x, pos_y, touched_now, released_now, repeat_pulse,
           time_since_touch, time_between_touches, start_x, start_y, last_x, last_y,
    input  ready
  );
  modport sink (
    input  valid, touching, pos_x, pos_y, touched_now, released_now, repeat_pulse,
           time_since_touch, time_between_touches, start_x, start_y, last_x, last_y,
    output ready
  );
endinterface

[sv/tsq_cfg.sv]
// Configuration register bank with its write decode.
module tsq_cfg import tsq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output tsq_cfg_t                 cfg_o
);

  tsq_cfg_t cfg_d, cfg_q;

  // Write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (tsq_cfg_idx_e'(cfg_idx_i))
        CFG_START_DELAY: cfg_d.start_delay = cfg_data_i[REPEAT_BITS-1:0];
        CFG_INTERVAL:    cfg_d.interval    = cfg_data_i[REPEAT_BITS-1:0];
        CFG_SCREEN_W:    cfg_d.screen_w    = cfg_data_i[SCREEN_BITS-1:0];
        CFG_SCREEN_H:    cfg_d.screen_h    = cfg_data_i[SCREEN_BITS-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay <= RST_START_DELAY;
      cfg_q.interval    <= RST_INTERVAL;
      cfg_q.screen_w    <= RST_SCREEN_W;
      cfg_q.screen_h    <= RST_SCREEN_H;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/tsq_track.sv]
// Touch tracking state: qualification, edges, auto-repeat and tick counters.
module tsq_track import tsq_pkg::*; #(
  parameter int unsigned COORD_BITS = TSQ_COORD_BITS,
  parameter int unsigned TIME_BITS  = TSQ_TIME_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  tsq_cfg_t                   cfg_i,
  input  logic                       opcode_i,
  input  logic                       pen_down_i,
  input  logic                       lid_closed_i,
  input  logic                       invalid_x_i,
  input  logic                       invalid_y_i,
  input  logic [COORD_BITS-1:0]      sample_x_i,
  input  logic [COORD_BITS-1:0]      sample_y_i,
  input  logic [ELAPSED_BITS-1:0]    elapsed_i,
  output logic                       touching_o,
  output logic signed [COORD_BITS:0] pos_x_o,
  output logic signed [COORD_BITS:0] pos_y_o,
  output logic                       touched_now_o,
  output logic                       released_now_o,
  output logic                       repeat_pulse_o,
  output logic [TIME_BITS-1:0]       since_o,
  output logic [TIME_BITS-1:0]       between_o,
  output logic signed [COORD_BITS:0] start_x_o,
  output logic signed [COORD_BITS:0] start_y_o,
  output logic signed [COORD_BITS:0] last_x_o,
  output logic signed [COORD_BITS:0] last_y_o
);

  localparam int unsigned PW = COORD_BITS + 1;
  localparam int unsigned SW = (TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS;
  localparam int unsigned CW = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;
  localparam logic [SW:0] TMAX_EXT = {{(SW + 1 - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  logic                 touch_d, touch_q;
  logic signed [PW-1:0] pos_x_d, pos_x_q, pos_y_d, pos_y_q;
  logic [TIME_BITS-1:0] accum_d, accum_q;
  logic [REPEAT_BITS-1:0] rep_d, rep_q;
  logic [TIME_BITS-1:0] since_d, since_q, between_d, between_q;
  logic signed [PW-1:0] down_x_d, down_x_q, down_y_d, down_y_q;
  logic signed [PW-1:0] held_x_d, held_x_q, held_y_d, held_y_q;

  logic                 dn, up, rep_pulse;
  logic [SW-1:0]        el_ext, acc_ext, spd;
  logic [SW:0]          add_sum, since_sum;
  logic [TIME_BITS-1:0] since_sat;
  logic signed [PW-1:0] part_x, part_y;
  logic                 in_area;

  // Step time is the larger of the accumulated and the item's own ticks
  assign el_ext    = SW'(elapsed_i);
  assign acc_ext   = SW'(accum_q);
  assign spd       = (acc_ext < el_ext) ? el_ext : acc_ext;
  assign add_sum   = (SW + 1)'(accum_q) + (SW + 1)'(elapsed_i);
  assign since_sum = (SW + 1)'(since_q) + (SW + 1)'(spd);
  assign since_sat = (since_sum < TMAX_EXT) ? since_sum[TIME_BITS-1:0] : '1;

  // Partial sample: update the valid axes only, then check the screen area
  assign part_x  = invalid_x_i ? pos_x_q : $signed({1'b0, sample_x_i});
  assign part_y  = invalid_y_i ? pos_y_q : $signed({1'b0, sample_y_i});
  assign in_area = !part_x[PW-1] && !part_y[PW-1]
                && (CW'(part_x[COORD_BITS-1:0]) < CW'(cfg_i.screen_w))
                && (CW'(part_y[COORD_BITS-1:0]) < CW'(cfg_i.screen_h));

  // Next state for one item
  always_comb begin
    touch_d   = touch_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    accum_d   = accum_q;
    rep_d     = rep_q;
    since_d   = since_q;
    between_d = between_q;
    down_x_d  = down_x_q;
    down_y_d  = down_y_q;
    held_x_d  = held_x_q;
    held_y_d  = held_y_q;
    dn        = 1'b0;
    up        = 1'b0;
    rep_pulse = 1'b0;

    unique case (tsq_op_e'(opcode_i))
      OP_ADD_TIME: begin
        accum_d = (add_sum >= TMAX_EXT) ? '1 : add_sum[TIME_BITS-1:0];
      end
      OP_SAMPLE: begin
        // Qualify the sample
        if (pen_down_i && !lid_closed_i) begin
          if (!invalid_x_i && !invalid_y_i) begin
            touch_d = 1'b1;
            pos_x_d = $signed({1'b0, sample_x_i});
            pos_y_d = $signed({1'b0, sample_y_i});
          end else if (in_area) begin
            touch_d = 1'b1;
            pos_x_d = part_x;
            pos_y_d = part_y;
          end else begin
            touch_d = 1'b0;
            pos_x_d = '1;
            pos_y_d = '1;
          end
        end else begin
          touch_d = 1'b0;
          pos_x_d = '1;
          pos_y_d = '1;
        end

        dn = !touch_q && touch_d;
        up = touch_q && !touch_d;

        // Auto-repeat countdown
        if (dn) begin
          rep_pulse = 1'b1;
          rep_d     = cfg_i.start_delay;
        end else if (touch_d && (rep_q != '0)) begin
          if (SW'(rep_q) > spd) begin
            rep_d = rep_q - spd[REPEAT_BITS-1:0];
          end else begin
            rep_pulse = 1'b1;
            rep_d     = cfg_i.interval;
          end
        end

        // Tick counters and touch-down capture
        if (dn) begin
          between_d = since_sat;
          since_d   = '0;
          down_x_d  = pos_x_d;
          down_y_d  = pos_y_d;
        end else begin
          since_d = since_sat;
        end

        accum_d = TIME_BITS'(el_ext);

        if (touch_d) begin
          held_x_d = pos_x_d;
          held_y_d = pos_y_d;
        end
      end
      default: accum_d = accum_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_q   <= 1'b0;
      pos_x_q   <= '1;
      pos_y_q   <= '1;
      accum_q   <= TIME_BITS'(1);
      rep_q     <= '0;
      since_q   <= '1;
      between_q <= '1;
      down_x_q  <= '1;
      down_y_q  <= '1;
      held_x_q  <= PW'(HELD_RST_X);
      held_y_q  <= PW'(HELD_RST_Y);
    end else if (step_i) begin
      touch_q   <= touch_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      accum_q   <= accum_d;
      rep_q     <= rep_d;
      since_q   <= since_d;
      between_q <= between_d;
      down_x_q  <= down_x_d;
      down_y_q  <= down_y_d;
      held_x_q  <= held_x_d;
      held_y_q  <= held_y_d;
    end
  end

  // Result shows the state after this item
  assign touching_o     = touch_d;
  assign pos_x_o        = pos_x_d;
  assign pos_y_o        = pos_y_d;
  assign touched_now_o  = dn;
  assign released_now_o = up;
  assign repeat_pulse_o = rep_pulse;
  assign since_o        = since_d;
  assign between_o      = between_d;
  assign start_x_o      = down_x_d;
  assign start_y_o      = down_y_d;
  assign last_x_o       = held_x_d;
  assign last_y_o       = held_y_d;

endmodule

[sv/touch_sample_qualifier_repeat_core.sv]
// Touch sample qualifier top level: input register, tracking logic, result register.
//
// Usage:
//   sample_i takes one transaction per item: a touch sample (opcode OP_SAMPLE)
//   or an elapsed-time item (OP_ADD_TIME). result_o gives exactly one
//   transaction per item, in order: the qualified touch state, position,
//   touch-down/release edges, auto-repeat pulse, tick counters and the start
//   and last touched positions.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i, one per
//   clock, and take effect at once; write them only while no item is in flight.
// Throughput:
//   An accepted item is held in the input register, processed by the
//   tracking logic and lands in the result register when that register
//   advances. One item per cycle is sustained while result_o is ready;
//   the tracking state is updated as each item moves into the result register.
// Reset:
//   rst_ni clears the pipeline, restores the register defaults and sets the
//   tracking state to not touching, position -1, counters saturated.
// Stalls:
//   While a held result is not taken the result register holds; the input
//   register still fills, after which sample_i.ready drops until it drains.
module touch_sample_qualifier_repeat_core import tsq_pkg::*; #(
  parameter int unsigned COORD_BITS = TSQ_COORD_BITS,
  parameter int unsigned TIME_BITS  = TSQ_TIME_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  tsq_in_if.sink                   sample_i,
  tsq_out_if.source                result_o
);

  localparam int unsigned PW = COORD_BITS + 1;

  tsq_cfg_t cfg;

  // Input register
  logic                    in_vld_q;
  logic                    opcode_q, pen_down_q, lid_closed_q, invalid_x_q, invalid_y_q;
  logic [COORD_BITS-1:0]   sample_x_q, sample_y_q;
  logic [ELAPSED_BITS-1:0] elapsed_q;

  // Result register
  logic                 out_vld_q;
  logic                 touching_q, touched_now_q, released_now_q, repeat_pulse_q;
  logic signed [PW-1:0] pos_x_q, pos_y_q, start_x_q, start_y_q, last_x_q, last_y_q;
  logic [TIME_BITS-1:0] since_q, between_q;

  // Tracking results
  logic                 touching_d, touched_now_d, released_now_d, repeat_pulse_d;
  logic signed [PW-1:0] pos_x_d, pos_y_d, start_x_d, start_y_d, last_x_d, last_y_d;
  logic [TIME_BITS-1:0] since_d, between_d;

  logic adv, step, in_fire;

  // Handshake: the result register advances when empty or being taken
  assign adv            = !out_vld_q || result_o.ready;
  assign step           = in_vld_q && adv;
  assign sample_i.ready = !in_vld_q || adv;
  assign in_fire        = sample_i.valid && sample_i.ready;

  tsq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tsq_track #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cfg_i          (cfg),
    .opcode_i       (opcode_q),
    .pen_down_i     (pen_down_q),
    .lid_closed_i   (lid_closed_q),
    .invalid_x_i    (invalid_x_q),
    .invalid_y_i    (invalid_y_q),
    .sample_x_i     (sample_x_q),
    .sample_y_i     (sample_y_q),
    .elapsed_i      (elapsed_q),
    .touching_o     (touching_d),
    .pos_x_o        (pos_x_d),
    .pos_y_o        (pos_y_d),
    .touched_now_o  (touched_now_d),
    .released_now_o (released_now_d),
    .repeat_pulse_o (repeat_pulse_d),
    .since_o        (since_d),
    .between_o      (between_d),
    .start_x_o      (start_x_d),
    .start_y_o      (start_y_d),
    .last_x_o       (last_x_d),
    .last_y_o       (last_y_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Input payload capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      opcode_q     <= sample_i.opcode;
      pen_down_q   <= sample_i.pen_down;
      lid_closed_q <= sample_i.lid_closed;
      invalid_x_q  <= sample_i.invalid_x;
      invalid_y_q  <= sample_i.invalid_y;
      sample_x_q   <= sample_i.sample_x;
      sample_y_q   <= sample_i.sample_y;
      elapsed_q    <= sample_i.elapsed;
    end
  end

  // Result payload capture
  always_ff @(posedge clk_i) begin
    if (step) begin
      touching_q     <= touching_d;
      pos_x_q        <= pos_x_d;
      pos_y_q        <= pos_y_d;
      touched_now_q  <= touched_now_d;
      released_now_q <= released_now_d;
      repeat_pulse_q <= repeat_pulse_d;
      since_q        <= since_d;
      between_q      <= between_d;
      start_x_q      <= start_x_d;
      start_y_q      <= start_y_d;
      last_x_q       <= last_x_d;
      last_y_q       <= last_y_d;
    end
  end

  assign result_o.valid                = out_vld_q;
  assign result_o.touching             = touching_q;
  assign result_o.pos_x                = pos_x_q;
  assign result_o.pos_y                = pos_y_q;
  assign result_o.touched_now          = touched_now_q;
  assign result_o.released_now         = released_now_q;
  assign result_o.repeat_pulse         = repeat_pulse_q;
  assign result_o.time_since_touch     = since_q;
  assign result_o.time_between_touches = between_q;
  assign result_o.start_x              = start_x_q;
  assign result_o.start_y              = start_y_q;
  assign result_o.last_x               = last_x_q;
  assign result_o.last_y               = last_y_q;

  // A touch-down restarts the repeat sequence and the tick counter
  a_touch_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && touched_now_q |->
      touching_q && repeat_pulse_q && (since_q == '0) && !released_now_q)
    else $error("touch-down result inconsistent");

  // Not touching always reports position -1
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !touching_q |-> (pos_x_q == '1) && (pos_y_q == '1))
    else $error("position not cleared while not touching");

  // A release leaves the block not touching and gives no repeat
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && released_now_q |-> !touching_q && !repeat_pulse_q)
    else $error("release result inconsistent");

  // An item in the input register reaches the result register once it advances
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed item lost");

endmodule
